### sv/ldsl_pkg.sv
package ldsl_pkg;

    localparam int DIGITS = 9;
    localparam int DIGIT_W = 4;
    localparam int LATCH_DIGITS = 9;
    localparam int LATCH_W = LATCH_DIGITS * DIGIT_W;
    localparam int PACK_DIGITS = (DIGITS < LATCH_DIGITS) ? DIGITS : LATCH_DIGITS;
    localparam int LAST = DIGITS - 1;
    localparam int PREV = DIGITS - 2;

    localparam logic [DIGIT_W-1:0] LOW3_MASK = 4'h7;
    localparam logic [DIGIT_W-1:0] HIGH_BIT = 4'h8;

    typedef logic [DIGIT_W-1:0] digit_t;
    typedef digit_t [DIGITS-1:0] digits_t;

    typedef enum logic [3:0] {
        MODE_SHIFT_DEC   = 4'd0,
        MODE_PART_DEC    = 4'd1,
        MODE_SHIFT_LOW3  = 4'd2,
        MODE_SHIFT_SET8  = 4'd3,
        MODE_LATCH_ALL   = 4'd4,
        MODE_LATCH_LAST2 = 4'd5,
        MODE_TOGGLE_BANK = 4'd6,
        MODE_LOAD_BANK   = 4'd7,
        MODE_SEG_CLR     = 4'd8,
        MODE_SEG_SET     = 4'd9
    } mode_t;

    typedef struct packed {
        logic [3:0] mode;
        logic [3:0] acc_value;
    } cmd_t;

    typedef struct packed {
        logic [LATCH_W-1:0] display_latch;
        logic               backplate;
        logic               latch_changed;
    } disp_t;

    function automatic digit_t seg_lookup(input logic [4:0] idx);
        digit_t v;
        v = 4'h0;
        unique case (idx)
            5'd0:  v = 4'he;
            5'd1:  v = 4'h0;
            5'd2:  v = 4'hc;
            5'd3:  v = 4'h8;
            5'd4:  v = 4'h2;
            5'd5:  v = 4'ha;
            5'd6:  v = 4'he;
            5'd7:  v = 4'h2;
            5'd8:  v = 4'he;
            5'd9:  v = 4'ha;
            5'd10: v = 4'h0;
            5'd11: v = 4'h0;
            5'd12: v = 4'h2;
            5'd13: v = 4'ha;
            5'd14: v = 4'h2;
            5'd15: v = 4'h2;
            5'd16: v = 4'hb;
            5'd17: v = 4'h9;
            5'd18: v = 4'h7;
            5'd19: v = 4'hf;
            5'd20: v = 4'hd;
            5'd21: v = 4'he;
            5'd22: v = 4'he;
            5'd23: v = 4'hb;
            5'd24: v = 4'hf;
            5'd25: v = 4'hf;
            5'd26: v = 4'h4;
            5'd27: v = 4'h0;
            5'd28: v = 4'hd;
            5'd29: v = 4'he;
            5'd30: v = 4'h4;
            5'd31: v = 4'h0;
            default: v = 4'h0;
        endcase
        return v;
    endfunction

endpackage

### sv/lcd_digit_shift_latch.sv
// LCD digit shift latch: display output unit of a 4-bit LCD controller.
// Command channel (cmd_valid / cmd_stall / cmd): one item is a display
// instruction (mode) with the current accumulator value. Display channel
// (disp_valid / disp_stall / disp): one item per command, carrying the packed
// output latch, the backplate bit and a flag for a latch copy.
// A command accepted into the command register executes, and its result item
// is registered in the result register. Throughput: one item per cycle unless
// stalled; the staging shift, latch copy and flag updates finish on execute.
// The command register and the result register form a two-stage pipe, so a
// new command is taken while a finished result still waits on disp_stall.
// When the receiver stalls, the result holds; the command register then
// fills and cmd_stall rises until the receiver takes the result.
// Reset (rst_n low, asynchronous) clears the staging digits, the output
// latch, the bank, segment-mode and backplate bits, and both valid bits.
module lcd_digit_shift_latch (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_stall,
    input  ldsl_pkg::cmd_t  cmd,
    output logic            disp_valid,
    input  logic            disp_stall,
    output ldsl_pkg::disp_t disp
);
    import ldsl_pkg::*;

    logic  cmd_valid_reg;
    cmd_t  cmd_reg;
    logic  disp_valid_reg;
    disp_t disp_reg;
    disp_t result;
    logic  adv;
    logic  exec;

    assign adv       = !disp_valid_reg || !disp_stall;
    assign exec      = cmd_valid_reg && adv;
    assign cmd_stall = cmd_valid_reg && !adv;

    ldsl_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (exec),
        .cmd    (cmd_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg  <= 1'b0;
            disp_valid_reg <= 1'b0;
        end
        else
        begin
            if (!cmd_stall)
            begin
                cmd_valid_reg <= cmd_valid;
            end
            if (adv)
            begin
                disp_valid_reg <= cmd_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && !cmd_stall)
        begin
            cmd_reg <= cmd;
        end
        if (exec)
        begin
            disp_reg <= result;
        end
    end

    assign disp_valid = disp_valid_reg;
    assign disp       = disp_reg;

endmodule

### sv/ldsl_core.sv
module ldsl_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  ldsl_pkg::cmd_t cmd,
    output ldsl_pkg::disp_t result
);
    import ldsl_pkg::*;

    digits_t stage_reg, stage_next;
    digits_t latch_reg, latch_next;
    logic    bank_reg, bank_next;
    logic    segm_reg, segm_next;
    logic    bp_reg, bp_next;
    logic    changed;
    digit_t  decoded;
    digit_t  low3;
    digit_t  set8;

    always_comb
    begin
        decoded = seg_lookup({bank_reg, cmd.acc_value});
        if (!bank_reg && segm_reg)
        begin
            decoded[0] = 1'b1;
        end
        low3 = cmd.acc_value & LOW3_MASK;
        set8 = cmd.acc_value | HIGH_BIT;
    end

    always_comb
    begin
        stage_next = stage_reg;
        latch_next = latch_reg;
        bank_next  = bank_reg;
        segm_next  = segm_reg;
        bp_next    = bp_reg;
        changed    = 1'b0;
        if (en)
        begin
            unique case (cmd.mode)
                MODE_SHIFT_DEC:   stage_next = {decoded, stage_reg[DIGITS-1:1]};
                MODE_PART_DEC:
                begin
                    stage_next[PREV] = stage_reg[LAST];
                    stage_next[LAST] = decoded;
                end
                MODE_SHIFT_LOW3:  stage_next = {low3, stage_reg[DIGITS-1:1]};
                MODE_SHIFT_SET8:  stage_next = {set8, stage_reg[DIGITS-1:1]};
                MODE_LATCH_ALL:
                begin
                    latch_next = stage_reg;
                    changed    = 1'b1;
                end
                MODE_LATCH_LAST2:
                begin
                    latch_next[PREV] = stage_reg[PREV];
                    latch_next[LAST] = stage_reg[LAST];
                    changed          = 1'b1;
                end
                MODE_TOGGLE_BANK: bank_next = ~bank_reg;
                MODE_LOAD_BANK:
                begin
                    bp_next   = cmd.acc_value[0];
                    bank_next = cmd.acc_value[3];
                end
                MODE_SEG_CLR:     segm_next = 1'b0;
                MODE_SEG_SET:     segm_next = 1'b1;
                default:          stage_next = stage_reg;
            endcase
        end
    end

    always_comb
    begin
        result = '0;
        for (int i = 0; i < PACK_DIGITS; i++)
        begin
            result.display_latch[DIGIT_W*i +: DIGIT_W] = latch_next[i];
        end
        result.backplate     = bp_next;
        result.latch_changed = changed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
            latch_reg <= '0;
            bank_reg  <= 1'b0;
            segm_reg  <= 1'b0;
            bp_reg    <= 1'b0;
        end
        else
        begin
            stage_reg <= stage_next;
            latch_reg <= latch_next;
            bank_reg  <= bank_next;
            segm_reg  <= segm_next;
            bp_reg    <= bp_next;
        end
    end

endmodule

### sv/ldsl_checker.sv
module ldsl_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            cmd_valid,
    input logic            cmd_stall,
    input ldsl_pkg::cmd_t  cmd,
    input logic            disp_valid,
    input logic            disp_stall,
    input ldsl_pkg::disp_t disp
);
    import ldsl_pkg::*;

    // input backs up only behind a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> disp_valid && disp_stall)
        else $error("cmd_stall without a held result");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) ##1 !(disp_valid && disp_stall) |=> disp_valid)
        else $error("result item missing two cycles after command");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        disp_valid && disp_stall |=> disp_valid && $stable(disp))
        else $error("stalled result item changed");

    a_unchanged_latch: assert property (@(posedge clk) disable iff (!rst_n)
        disp_valid && disp_stall && !disp.latch_changed
            |=> $stable(disp.display_latch))
        else $error("latch moved while result held");

endmodule

bind lcd_digit_shift_latch ldsl_checker u_ldsl_checker (.*);
